FILE: sv/svac_pkg.sv
// Shared types and constants for the sigma-vote alert classifier.
// No dependencies; imported by the core and by its checker.
`default_nettype none

package svac_pkg;

	localparam int NUM_METRICS = 8;
	localparam int NUM_AXES    = 3;
	localparam int ENTRIES     = NUM_METRICS * NUM_AXES;
	localparam int IDX_W       = $clog2(ENTRIES);
	localparam int AXIS_W      = 2;
	localparam int METRIC_W    = 3;
	localparam int VAL_W       = 32;
	localparam int SIGMA_W     = 31;
	localparam int CMP_W       = 36;
	localparam int RUN_W       = 8;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 8;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_BASELINE_VALID  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_CONFIRM_WINDOWS = 1'b1;

	// Input word modes.
	localparam logic MODE_LOAD   = 1'b0;
	localparam logic MODE_SAMPLE = 1'b1;

	// Equipment state codes.
	localparam logic [1:0] ST_GREEN  = 2'd0;
	localparam logic [1:0] ST_YELLOW = 2'd1;
	localparam logic [1:0] ST_RED    = 2'd2;

	// Per-sample class codes.
	localparam logic [1:0] CLS_NORMAL   = 2'd0;
	localparam logic [1:0] CLS_WARNING  = 2'd1;
	localparam logic [1:0] CLS_CRITICAL = 2'd2;

	typedef struct packed {
		logic                      mode;
		logic [METRIC_W-1:0]       metric_index;
		logic [AXIS_W-1:0]         axis_index;
		logic signed [VAL_W-1:0]   sample_or_mean;
		logic [SIGMA_W-1:0]        sigma_value;
		logic                      window_end;
	} in_word_t;

	typedef struct packed {
		logic [1:0]       window_state;
		logic [1:0]       confirmed_state;
		logic [1:0]       pending_state;
		logic [RUN_W-1:0] pending_run;
	} out_word_t;

endpackage

`default_nettype wire

FILE: sv/sigma_vote_alert_classifier_core.sv
// Sigma-vote alert classifier: baseline table, per-sample classification,
// window vote and persistence filter. Depends on svac_pkg.
// A closing sample sits in the input register; its result word is then registered.
// Throughput: one input word per cycle, loads and samples alike; a closing sample
// waits in the input register only while the previous result word is still held.
// Reset (arst_n low) clears the input valid, counters, filter state and registers;
// the baseline table keeps whatever it held and must be loaded before use.
`default_nettype none

module sigma_vote_alert_classifier_core (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             cfg_we,
	input  wire [svac_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire [svac_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	input  wire                             in_valid,
	output logic                            in_ready,
	input  svac_pkg::in_word_t              in_data,
	output logic                            out_valid,
	input  wire                             out_ready,
	output svac_pkg::out_word_t             out_data
);
	import svac_pkg::*;

	// Configuration registers.
	logic             baseline_valid_q;
	logic [RUN_W-1:0] confirm_windows_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			baseline_valid_q  <= 1'b0;
			confirm_windows_q <= RUN_W'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_BASELINE_VALID:  baseline_valid_q  <= cfg_wdata[0];
				CFG_CONFIRM_WINDOWS: confirm_windows_q <= cfg_wdata[RUN_W-1:0];
				default: ;
			endcase
		end
	end

	// Baseline table: one mean and one sigma per metric and axis. It has no
	// reset; entries are meaningful only after they have been loaded.
	logic signed [VAL_W-1:0] mean_q  [ENTRIES];
	logic [SIGMA_W-1:0]      sigma_q [ENTRIES];

	// The input register holds the accepted word. A load writes the table
	// and retires; a sample is classified, folded into its axis and, when it
	// closes the window, voted into the result register in the same pass.
	logic     s1_valid;
	in_word_t s1_data;

	// Window counters and persistence filter state.
	logic [1:0]       warn_q [NUM_AXES];
	logic             crit_q [NUM_AXES];
	logic [1:0]       cur_q;
	logic [1:0]       cand_q;
	logic [RUN_W-1:0] run_q;

	// Output register.
	logic      out_valid_q;
	out_word_t out_data_q;

	// Handshake: only a window-closing sample needs room in the output
	// register, so other words keep flowing while a result waits.
	logic s1_is_load;
	logic s1_fire;
	logic s1_sample_fire;
	logic s1_close;

	assign s1_is_load     = s1_data.mode == MODE_LOAD;
	assign s1_fire        = s1_valid && (s1_is_load || !s1_data.window_end ||
		!out_valid_q || out_ready);
	assign s1_sample_fire = s1_fire && !s1_is_load;
	assign s1_close       = s1_sample_fire && s1_data.window_end;
	assign in_ready       = !s1_valid || s1_fire;

	// Address and classify.
	logic             s1_in_range;
	logic [IDX_W-1:0] s1_idx;

	assign s1_in_range = (int'(s1_data.metric_index) < NUM_METRICS) &&
		(int'(s1_data.axis_index) < NUM_AXES);
	assign s1_idx = s1_in_range ?
		IDX_W'(int'(s1_data.metric_index) * NUM_AXES + int'(s1_data.axis_index)) : '0;

	logic signed [CMP_W-1:0] v_ext;
	logic signed [CMP_W-1:0] mean_ext;
	logic [CMP_W-1:0]        sig_x3;
	logic [CMP_W-1:0]        sig_x6;
	logic signed [CMP_W-1:0] warn_thr;
	logic signed [CMP_W-1:0] crit_thr;
	logic [1:0]              s1_cls;

	// Thresholds are mean + 3 sigma and mean + 6 sigma built from shifts;
	// at 36 bits neither the sums nor the compares can overflow.
	always_comb begin
		v_ext    = CMP_W'(s1_data.sample_or_mean);
		mean_ext = CMP_W'(mean_q[s1_idx]);
		sig_x3   = {5'b0, sigma_q[s1_idx]} + {4'b0, sigma_q[s1_idx], 1'b0};
		sig_x6   = {3'b0, sigma_q[s1_idx], 2'b0} + {4'b0, sigma_q[s1_idx], 1'b0};
		warn_thr = mean_ext + $signed(sig_x3);
		crit_thr = mean_ext + $signed(sig_x6);
		s1_cls   = CLS_NORMAL;
		if (s1_in_range && baseline_valid_q) begin
			if (v_ext > crit_thr) begin
				s1_cls = CLS_CRITICAL;
			end else if (v_ext > warn_thr) begin
				s1_cls = CLS_WARNING;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_valid && s1_is_load && s1_in_range) begin
			mean_q[s1_idx]  <= s1_data.sample_or_mean;
			sigma_q[s1_idx] <= s1_data.sigma_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (in_ready) begin
			s1_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			s1_data <= in_data;
		end
	end

	// Fold the sample into its axis, then vote if it closes the window.
	// The vote sees the counters including this sample.
	logic [1:0]       warn_n [NUM_AXES];
	logic             crit_n [NUM_AXES];
	logic [1:0]       vote;
	logic [1:0]       axis_st;
	logic [1:0]       cur_n;
	logic [1:0]       cand_n;
	logic [RUN_W-1:0] run_n;

	always_comb begin
		vote = ST_GREEN;
		for (int a = 0; a < NUM_AXES; a++) begin
			warn_n[a] = warn_q[a];
			crit_n[a] = crit_q[a];
			if (int'(s1_data.axis_index) == a) begin
				if (s1_cls == CLS_CRITICAL) begin
					crit_n[a] = 1'b1;
				end else if (s1_cls == CLS_WARNING && warn_q[a] != 2'd3) begin
					warn_n[a] = warn_q[a] + 2'd1;
				end
			end
			// Red on any critical or three warnings, yellow on one or two.
			if (crit_n[a] || warn_n[a] == 2'd3) begin
				axis_st = ST_RED;
			end else if (warn_n[a] != 2'd0) begin
				axis_st = ST_YELLOW;
			end else begin
				axis_st = ST_GREEN;
			end
			if (axis_st > vote) begin
				vote = axis_st;
			end
		end
		if (!baseline_valid_q) begin
			vote = ST_GREEN;
		end
	end

	// Persistence filter: a new state is confirmed only after it has been
	// the window state for confirm_windows windows in a row. A setting of
	// zero or one confirms every window at once.
	always_comb begin
		cur_n  = cur_q;
		cand_n = cand_q;
		run_n  = run_q;
		if (confirm_windows_q <= RUN_W'(1)) begin
			cur_n  = vote;
			cand_n = vote;
			run_n  = '0;
		end else if (vote == cur_q) begin
			cand_n = vote;
			run_n  = '0;
		end else begin
			if (vote == cand_q) begin
				run_n = (run_q == '1) ? run_q : run_q + RUN_W'(1);
			end else begin
				cand_n = vote;
				run_n  = RUN_W'(1);
			end
			if (run_n >= confirm_windows_q) begin
				cur_n  = vote;
				cand_n = vote;
				run_n  = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int a = 0; a < NUM_AXES; a++) begin
				warn_q[a] <= 2'd0;
				crit_q[a] <= 1'b0;
			end
			cur_q  <= ST_GREEN;
			cand_q <= ST_GREEN;
			run_q  <= '0;
		end else if (s1_sample_fire) begin
			for (int a = 0; a < NUM_AXES; a++) begin
				warn_q[a] <= s1_data.window_end ? 2'd0 : warn_n[a];
				crit_q[a] <= s1_data.window_end ? 1'b0 : crit_n[a];
			end
			if (s1_data.window_end) begin
				cur_q  <= cur_n;
				cand_q <= cand_n;
				run_q  <= run_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_close) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_close) begin
			out_data_q.window_state    <= vote;
			out_data_q.confirmed_state <= cur_n;
			out_data_q.pending_state   <= cand_n;
			out_data_q.pending_run     <= run_n;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

`default_nettype wire

FILE: sv/svac_checker.sv
// Port-level checks for the sigma-vote alert classifier, bound to the core.
// Depends on svac_pkg and sigma_vote_alert_classifier_core.
`default_nettype none

module svac_checker (
	input wire                             clk,
	input wire                             arst_n,
	input wire                             in_valid,
	input wire                             in_ready,
	input svac_pkg::in_word_t              in_data,
	input wire                             out_valid,
	input wire                             out_ready,
	input svac_pkg::out_word_t             out_data
);
	import svac_pkg::*;

	// An offered input word must hold until it is taken.
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(in_data))
		else $error("input word changed while stalled");

	// A waiting result word must hold until it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result word changed while stalled");

	// A run count is nonzero exactly while the candidate differs from the
	// confirmed state.
	a_run_pending: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((out_data.pending_run == '0) ==
			(out_data.pending_state == out_data.confirmed_state)))
		else $error("pending run inconsistent with pending state");

	// No state field ever carries the unused code.
	a_state_codes: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.window_state != 2'd3 &&
			out_data.confirmed_state != 2'd3 && out_data.pending_state != 2'd3)
		else $error("unused state code on output");

	// A window state that is not confirmed yet is always the pending candidate.
	a_bypass: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.window_state != out_data.confirmed_state |->
			out_data.pending_state == out_data.window_state)
		else $error("unconfirmed window state is not the candidate");

endmodule

bind sigma_vote_alert_classifier_core svac_checker u_svac_checker (.*);

`default_nettype wire

FILE: tb/svac_vote_checker.sv
// Scoreboard for the sigma-vote alert classifier core: follows register writes,
// predicts the verdict of every closed window and compares result words in order.
// Depends on svac_pkg.

module svac_vote_checker (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            cfg_we,
	input  wire [svac_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire [svac_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  wire                            in_valid,
	input  wire                            in_ready,
	input  svac_pkg::in_word_t             in_data,
	input  wire                            out_valid,
	input  wire                            out_ready,
	input  svac_pkg::out_word_t            out_data,
	output int                             mismatches,
	output int                             verdicts_owed
);
	import svac_pkg::*;

	logic signed [VAL_W-1:0] mean_tbl  [ENTRIES] = '{default: '0};
	logic [SIGMA_W-1:0]      sigma_tbl [ENTRIES] = '{default: '0};
	logic [1:0]              warn_cnt  [NUM_AXES];
	logic                    crit_seen [NUM_AXES];
	logic [1:0]              held_state;
	logic [1:0]              cand_state;
	logic [RUN_W-1:0]        cand_run;
	logic                    base_ok;
	logic [CFG_DATA_W-1:0]   confirm_k;
	out_word_t               verdict_q [$];
	int                      verdicts_seen;

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch in result word %0d: %s is %0d, expected %0d",
			verdicts_seen, what, got, want);
		mismatches++;
	endtask

	// Exact 64-bit compare of one sample against its baseline entry.
	function automatic logic [1:0] grade_sample(input int slot,
			input logic signed [VAL_W-1:0] v);
		longint val;
		longint mu;
		longint sg;
		val = longint'(v);
		mu = longint'(mean_tbl[slot]);
		sg = longint'(sigma_tbl[slot]);
		if (val > mu + 6 * sg)
			return CLS_CRITICAL;
		if (val > mu + 3 * sg)
			return CLS_WARNING;
		return CLS_NORMAL;
	endfunction

	// The worst axis gives the window class.
	function automatic logic [1:0] vote_axes();
		logic [1:0] worst;
		logic [1:0] axis_st;
		int a;
		worst = ST_GREEN;
		if (!base_ok)
			return ST_GREEN;
		for (a = 0; a < NUM_AXES; a++) begin
			axis_st = ST_GREEN;
			if (crit_seen[a] || warn_cnt[a] == 2'd3)
				axis_st = ST_RED;
			else if (warn_cnt[a] != 2'd0)
				axis_st = ST_YELLOW;
			if (axis_st > worst)
				worst = axis_st;
		end
		return worst;
	endfunction

	task automatic advance_filter(input logic [1:0] cls);
		if (confirm_k <= 1) begin
			cand_state = cls;
			cand_run = '0;
			held_state = cls;
			return;
		end
		if (cls == held_state) begin
			cand_state = cls;
			cand_run = '0;
			return;
		end
		if (cls == cand_state) begin
			if (cand_run != '1)
				cand_run++;
		end else begin
			cand_state = cls;
			cand_run = RUN_W'(1);
		end
		if (cand_run >= confirm_k) begin
			cand_run = '0;
			held_state = cls;
		end
	endtask

	task automatic absorb_word(input in_word_t w);
		int slot;
		int a;
		logic hit;
		logic [1:0] cls;
		out_word_t res;
		hit = (int'(w.metric_index) < NUM_METRICS) && (int'(w.axis_index) < NUM_AXES);
		slot = int'(w.metric_index) * NUM_AXES + int'(w.axis_index);
		if (w.mode == MODE_LOAD) begin
			if (hit) begin
				mean_tbl[slot] = w.sample_or_mean;
				sigma_tbl[slot] = w.sigma_value;
			end
			return;
		end
		if (hit && base_ok) begin
			cls = grade_sample(slot, w.sample_or_mean);
			if (cls == CLS_CRITICAL)
				crit_seen[w.axis_index] = 1'b1;
			else if (cls == CLS_WARNING && warn_cnt[w.axis_index] != 2'd3)
				warn_cnt[w.axis_index]++;
		end
		if (!w.window_end)
			return;
		cls = vote_axes();
		advance_filter(cls);
		for (a = 0; a < NUM_AXES; a++) begin
			warn_cnt[a] = '0;
			crit_seen[a] = 1'b0;
		end
		res.window_state = cls;
		res.confirmed_state = held_state;
		res.pending_state = cand_state;
		res.pending_run = cand_run;
		verdict_q.push_back(res);
	endtask

	task automatic check_verdict();
		out_word_t want;
		verdicts_seen++;
		if (verdict_q.size() == 0) begin
			report_mismatch("word with no verdict pending", 32'(out_data), 32'd0);
			return;
		end
		want = verdict_q.pop_front();
		if (out_data.window_state !== want.window_state)
			report_mismatch("window_state", 32'(out_data.window_state),
				32'(want.window_state));
		if (out_data.confirmed_state !== want.confirmed_state)
			report_mismatch("confirmed_state", 32'(out_data.confirmed_state),
				32'(want.confirmed_state));
		if (out_data.pending_state !== want.pending_state)
			report_mismatch("pending_state", 32'(out_data.pending_state),
				32'(want.pending_state));
		if (out_data.pending_run !== want.pending_run)
			report_mismatch("pending_run", 32'(out_data.pending_run),
				32'(want.pending_run));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int a = 0; a < NUM_AXES; a++) begin
				warn_cnt[a] = '0;
				crit_seen[a] = 1'b0;
			end
			held_state = ST_GREEN;
			cand_state = ST_GREEN;
			cand_run = '0;
			base_ok = 1'b0;
			confirm_k = 8'd1;
			verdict_q.delete();
			verdicts_seen = 0;
			verdicts_owed = 0;
			mismatches = 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_BASELINE_VALID)
					base_ok = cfg_wdata[0];
				else if (cfg_index == CFG_CONFIRM_WINDOWS)
					confirm_k = cfg_wdata;
			end
			if (out_valid && out_ready)
				check_verdict();
			if (in_valid && in_ready)
				absorb_word(in_data);
			verdicts_owed = verdict_q.size();
		end
	end

endmodule

FILE: tb/tb_sigma_vote_alert_classifier_core.sv
// Regression bench for the sigma-vote alert classifier core: directed threshold
// and vote cases, then randomized windows under several register settings.
// Depends on svac_pkg, sigma_vote_alert_classifier_core and svac_vote_checker.

module tb_sigma_vote_alert_classifier_core;
	import svac_pkg::*;

	// The run is far shorter than this; the limit only catches a hung handshake.
	localparam int CYCLE_LIMIT = 600000;
	// Loads and open-window samples leave no trace on the output, so these spare
	// cycles after the last result word let them retire.
	localparam int FLUSH_CYCLES = 6;
	// Long receiver hold-off that fills the pipeline and back-pressures the input.
	localparam int HOLD_CYCLES = 400;
	localparam int PHASE_SAMPLES = 140;
	localparam longint Q_MAX = 64'sd2147483647;
	localparam longint Q_MIN = -64'sd2147483648;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = CFG_BASELINE_VALID;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	in_word_t              in_data = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	out_word_t             out_data;
	int                    mismatches;
	int                    verdicts_owed;
	int                    cycles = 0;
	int                    samples_sent = 0;
	bit                    steady = 1'b0;
	bit                    hold_off_pending = 1'b0;

	// Copy of what was loaded into the baseline table, used only to aim sample
	// values at either side of the three- and six-sigma thresholds.
	longint mean_shadow  [ENTRIES] = '{default: 0};
	longint sigma_shadow [ENTRIES] = '{default: 0};

	sigma_vote_alert_classifier_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	svac_vote_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.in_data       (in_data),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.out_data      (out_data),
		.mismatches    (mismatches),
		.verdicts_owed (verdicts_owed)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Watchdog: a stuck handshake ends the run as a failure.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("sigma_vote_alert_classifier_core regression: fail");
			$finish;
		end
	end

	// Idle length for either side: mostly none or short, now and then long.
	// In a steady stretch neither side idles at all.
	function automatic int pick_gap();
		int r;
		if (steady)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 2);
		if (r < 97)
			return $urandom_range(3, 6);
		return $urandom_range(10, 40);
	endfunction

	function automatic in_word_t make_word(input logic op, input int m, input int a,
			input longint v, input longint sg, input bit closes);
		in_word_t w;
		w.mode = op;
		w.metric_index = m[METRIC_W-1:0];
		w.axis_index = a[AXIS_W-1:0];
		w.sample_or_mean = v[VAL_W-1:0];
		w.sigma_value = sg[SIGMA_W-1:0];
		w.window_end = closes;
		return w;
	endfunction

	function automatic longint threshold(input int m, input int a, input int mult);
		return mean_shadow[m * NUM_AXES + a] + mult * sigma_shadow[m * NUM_AXES + a];
	endfunction

	// Picks a value that lands in the requested class for entry (m, a): one of the
	// class's two bounds or a uniform point between them. When the class cannot
	// be reached inside the Q16.16 range, any value will do.
	function automatic longint aim_value(input int m, input int a, input logic [1:0] level);
		longint lo;
		longint hi;
		longint span;
		longint rnd;
		case (level)
			CLS_NORMAL: begin
				lo = Q_MIN;
				hi = threshold(m, a, 3);
			end
			CLS_WARNING: begin
				lo = threshold(m, a, 3) + 1;
				hi = threshold(m, a, 6);
			end
			default: begin
				lo = threshold(m, a, 6) + 1;
				hi = Q_MAX;
			end
		endcase
		if (hi > Q_MAX)
			hi = Q_MAX;
		if (lo < Q_MIN)
			lo = Q_MIN;
		if (lo > hi)
			return $signed($urandom());
		span = hi - lo;
		rnd = $urandom();
		case ($urandom_range(0, 3))
			0: return lo;
			1: return hi;
			default: return lo + rnd % (span + 1);
		endcase
	endfunction

	// Offers one word and returns at the clock edge where it is taken. The ready
	// line is looked at on the falling edge, where it has settled, so the
	// following rising edge is the one that moves the word.
	task automatic push_word(input in_word_t w);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= w;
		@(negedge clk);
		while (!in_ready)
			@(negedge clk);
		@(posedge clk);
	endtask

	task automatic send_sample(input int m, input int a, input longint v, input bit closes);
		push_word(make_word(MODE_SAMPLE, m, a, v, $urandom(), closes));
		samples_sent++;
	endtask

	// Loads for an axis beyond the table are sent too, but the block must drop them.
	task automatic load_entry(input int m, input int a, input longint mu, input longint sg,
			input bit closes);
		if (a < NUM_AXES) begin
			mean_shadow[m * NUM_AXES + a] = $signed(mu[VAL_W-1:0]);
			sigma_shadow[m * NUM_AXES + a] = sg[SIGMA_W-1:0];
		end
		push_word(make_word(MODE_LOAD, m, a, mu, sg, closes));
	endtask

	// Stops offering words, waits for every predicted result word, then lets the
	// pipeline empty of words that produce no result.
	task automatic drain();
		in_valid <= 1'b0;
		@(negedge clk);
		while (verdicts_owed != 0)
			@(negedge clk);
		repeat (FLUSH_CYCLES) @(posedge clk);
	endtask

	// Writes both registers on back-to-back cycles; only called with the block idle.
	task automatic configure(input logic valid_bit, input logic [CFG_DATA_W-1:0] k);
		cfg_we <= 1'b1;
		cfg_index <= CFG_BASELINE_VALID;
		cfg_wdata <= {{(CFG_DATA_W-1){1'b0}}, valid_bit};
		@(posedge clk);
		cfg_index <= CFG_CONFIRM_WINDOWS;
		cfg_wdata <= k;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Rewrites a random entry mid-run. Most means and sigmas are modest so that
	// every class stays reachable; some are full-range or extreme.
	task automatic random_reload();
		int r;
		longint mu;
		longint sg;
		r = $urandom_range(0, 99);
		if (r < 60)
			mu = longint'($urandom_range(0, 1 << 25)) - (1 << 24);
		else if (r < 80)
			mu = $signed($urandom());
		else if (r < 90)
			mu = Q_MAX;
		else
			mu = Q_MIN;
		r = $urandom_range(0, 99);
		if (r < 70)
			sg = $urandom_range(0, 1 << 20);
		else if (r < 85)
			sg = $urandom_range(0, 32'h7fff_ffff);
		else if (r < 93)
			sg = 0;
		else
			sg = 32'h7fff_ffff;
		load_entry($urandom_range(0, NUM_METRICS - 1),
			($urandom_range(0, 99) < 8) ? (1 << AXIS_W) - 1 : $urandom_range(0, NUM_AXES - 1),
			mu, sg, $urandom_range(0, 1));
	endtask

	// One window of one to five samples whose classes lean toward the target
	// state. Samples on the unused axis, raw values and stray reloads are mixed in.
	task automatic random_window(input logic [1:0] target);
		int n;
		int i;
		int m;
		int a;
		int warns;
		logic [1:0] level;
		longint v;
		n = $urandom_range(1, 5);
		warns = 0;
		for (i = 0; i < n; i++) begin
			if ($urandom_range(0, 99) < 6)
				random_reload();
			m = $urandom_range(0, NUM_METRICS - 1);
			a = ($urandom_range(0, 99) < 7) ? (1 << AXIS_W) - 1 : $urandom_range(0, NUM_AXES - 1);
			case (target)
				ST_GREEN: level = CLS_NORMAL;
				ST_YELLOW: level = (warns < 2 && $urandom_range(0, 1)) ? CLS_WARNING : CLS_NORMAL;
				default: level = $urandom_range(0, 1) ? CLS_CRITICAL : CLS_WARNING;
			endcase
			if (level == CLS_WARNING)
				warns++;
			if (a >= NUM_AXES || $urandom_range(0, 99) < 3)
				v = $signed($urandom());
			else
				v = aim_value(m, a, level);
			send_sample(m, a, v, i == n - 1);
		end
	endtask

	// One register setting and a batch of windows. The target state wanders so
	// that the persistence filter sees both short and long runs of equal windows.
	task automatic run_phase(input logic valid_bit, input logic [CFG_DATA_W-1:0] k,
			input bit calm, input bit squeeze);
		logic [1:0] target;
		int first;
		drain();
		configure(valid_bit, k);
		if (squeeze)
			hold_off_pending = 1'b1;
		target = ST_GREEN;
		first = samples_sent;
		while (samples_sent - first < PHASE_SAMPLES) begin
			steady = calm ? 1'b1 : ($urandom_range(0, 99) < 20);
			if ($urandom_range(0, 99) < 25)
				target = 2'($urandom_range(0, 2));
			random_window(target);
		end
		steady = 1'b0;
	endtask

	// Receiver: ready toggles in stretches of random length. When the stimulus
	// asks for it, ready stays low for a long fixed stretch, counted here.
	initial begin
		@(posedge clk);
		forever begin
			if (hold_off_pending) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_off_pending = 1'b0;
			end else begin
				if (pick_gap() > 0) begin
					out_ready <= 1'b0;
					repeat (pick_gap() + 1) @(posedge clk);
				end
				out_ready <= 1'b1;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
		end
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Start with the baseline marked unusable so the first window is green.
		configure(1'b0, 8'd1);

		// Fill the whole table first; no sample may hit an entry never loaded.
		// Entry (0,0) holds the most negative mean with zero sigma, entry (7,2)
		// the largest mean and sigma; the rest hold small round Q16.16 numbers.
		for (int m = 0; m < NUM_METRICS; m++) begin
			for (int a = 0; a < NUM_AXES; a++) begin
				if (m == 0 && a == 0)
					load_entry(m, a, Q_MIN, 0, 1'b0);
				else if (m == NUM_METRICS - 1 && a == NUM_AXES - 1)
					load_entry(m, a, Q_MAX, 32'h7fff_ffff, 1'b0);
				else
					load_entry(m, a, (m - 4) * 65536, (a + 1) * 32768, 1'b0);
			end
		end
		// A load on the unused axis, with its window-end bit set, changes nothing.
		load_entry(3, (1 << AXIS_W) - 1, Q_MAX, 0, 1'b1);

		// A critical value while the baseline is unusable still votes green.
		send_sample(1, 0, aim_value(1, 0, CLS_CRITICAL), 1'b1);

		drain();
		configure(1'b1, 8'd1);

		// Entry (1,1) has mean -3.0 and sigma 1.0: values exactly on each
		// threshold do not cross it, one LSB above does.
		send_sample(1, 1, threshold(1, 1, 3), 1'b1);
		send_sample(1, 1, threshold(1, 1, 3) + 1, 1'b1);
		send_sample(1, 1, threshold(1, 1, 6), 1'b1);
		send_sample(1, 1, threshold(1, 1, 6) + 1, 1'b1);

		// Three warnings on axis 0, one metric repeated, make the axis red.
		send_sample(2, 0, aim_value(2, 0, CLS_WARNING), 1'b0);
		send_sample(2, 0, aim_value(2, 0, CLS_WARNING), 1'b0);
		send_sample(3, 0, aim_value(3, 0, CLS_WARNING), 1'b1);

		// Four warnings on axis 1 run the counter into saturation; the window
		// closes on a normal sample of another axis.
		for (int m = 4; m < 8; m++)
			send_sample(m, 1, aim_value(m, 1, CLS_WARNING), 1'b0);
		send_sample(5, 2, aim_value(5, 2, CLS_NORMAL), 1'b1);

		// Two warnings on one axis give yellow.
		send_sample(6, 2, aim_value(6, 2, CLS_WARNING), 1'b0);
		send_sample(0, 2, aim_value(0, 2, CLS_WARNING), 1'b1);

		// Ends of the value range against the extreme entries.
		send_sample(0, 0, Q_MIN, 1'b1);
		send_sample(0, 0, Q_MIN + 1, 1'b1);
		send_sample(7, 2, Q_MAX, 1'b1);

		// A sample on the unused axis counts nothing but still closes the window.
		send_sample(7, 0, aim_value(7, 0, CLS_WARNING), 1'b0);
		send_sample(5, (1 << AXIS_W) - 1, Q_MAX, 1'b1);

		// Random phases. The second one holds the receiver off for a long stretch
		// while the sender keeps offering words back to back.
		run_phase(1'b1, 8'd2, 1'b0, 1'b0);
		run_phase(1'b1, 8'd0, 1'b1, 1'b1);
		run_phase(1'b0, 8'd3, 1'b0, 1'b0);
		run_phase(1'b1, 8'd3, 1'b0, 1'b0);
		run_phase(1'b1, 8'd255, 1'b0, 1'b0);
		run_phase(1'b1, 8'($urandom_range(4, 8)), 1'b0, 1'b0);
		run_phase(1'b1, 8'd1, 1'b0, 1'b0);

		drain();
		if (mismatches == 0)
			$display("sigma_vote_alert_classifier_core regression: pass");
		else
			$display("sigma_vote_alert_classifier_core regression: fail");
		$finish;
	end

endmodule

FILE: sigma_vote_alert_classifier_core.f
sv/svac_pkg.sv
sv/sigma_vote_alert_classifier_core.sv
sv/svac_checker.sv
tb/svac_vote_checker.sv
tb/tb_sigma_vote_alert_classifier_core.sv
